### hw/rtl/mipsdram_pkg.sv
// ----------------------------------------------------------------------------
// mipsdram_pkg
// Shared constants for the small integer core with open-row memory timing:
// command, status and row outcome codes, register indexes and field widths.
// ----------------------------------------------------------------------------
package mipsdram_pkg;

    // default memory geometry
    localparam int DEF_ROW_WORDS = 256;
    localparam int DEF_ROW_COUNT = 64;

    // field widths
    localparam int DATA_W    = 32;
    localparam int REG_AW    = 5;
    localparam int REG_COUNT = 32;
    localparam int CMD_W     = 3;
    localparam int STAT_W    = 3;
    localparam int OUTC_W    = 2;
    localparam int DLY_W     = 16;
    localparam int ROW_IDX_W = 10;
    localparam int CFG_AW    = 1;

    // stream widths, padded to whole bytes
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 136;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADDI  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LW    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SW    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DRAIN = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
    localparam logic [STAT_W-1:0] ST_OVF   = 3'd1;
    localparam logic [STAT_W-1:0] ST_UNAL  = 3'd2;
    localparam logic [STAT_W-1:0] ST_BADDR = 3'd3;
    localparam logic [STAT_W-1:0] ST_ZDEST = 3'd4;

    // row buffer outcome codes
    localparam logic [OUTC_W-1:0] OUTC_HIT      = 2'd0;
    localparam logic [OUTC_W-1:0] OUTC_CLOSED   = 2'd1;
    localparam logic [OUTC_W-1:0] OUTC_CONFLICT = 2'd2;
    localparam logic [OUTC_W-1:0] OUTC_NONE     = 2'd3;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_ROW_DELAY = 1'd0;
    localparam logic [CFG_AW-1:0] CFG_COL_DELAY = 1'd1;

    // configuration reset values
    localparam logic [DLY_W-1:0] ROW_DELAY_RST = 16'd10;
    localparam logic [DLY_W-1:0] COL_DELAY_RST = 16'd2;

endpackage

### hw/rtl/mips_subset_core_with_dram_row_buffer.sv
// ----------------------------------------------------------------------------
// mips_subset_core_with_dram_row_buffer
// Executes add, addi, lw, sw and drain items against a register file and a
// word memory, and tracks a simulated open-row memory timeline.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass that zeroes the word memory and
// the register file; s_axis_tready stays low during it, configuration writes are
// taken at any time. Afterwards add, addi, drain and unknown commands enter at
// one item per cycle; an lw holds off the next item while it sits in the stage 1
// or stage 2 registers, since its loaded word comes out of the synchronous word
// memory only in the timeline update stage and is forwarded to the next register
// read only through the write-back bypass. Results leave in item order through
// an output register; a stalled output stalls the whole pipeline. Stages:
// register file read, operand/address and error checks with add/addi
// write-back, row index and word memory access, timeline update.
module mips_subset_core_with_dram_row_buffer
    import mipsdram_pkg::*;
#(
    parameter int ROW_WORDS = DEF_ROW_WORDS,
    parameter int ROW_COUNT = DEF_ROW_COUNT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // dest_reg[4:0], src_a_reg[9:5], src_b_reg[14:10], immediate[46:15]
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // command[2:0]
    input  logic [CMD_W-1:0]      s_axis_tuser,
    // result items
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // status[2:0], value[34:3], row_outcome[36:35], cycle_count[68:37],
    // activation_count[100:69], pending_end[132:101]
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_AW-1:0]     i_cfg_index,
    input  logic [DLY_W-1:0]      i_cfg_data
);

    // geometry and row index reciprocal
    localparam int MEM_WORDS = ROW_WORDS * ROW_COUNT;
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam int ROW_LG    = $clog2(ROW_WORDS);
    localparam int RCP_SH    = MEM_AW + ROW_LG;
    localparam int RCP_W     = MEM_AW + 1;
    localparam int PROD_W    = MEM_AW + RCP_W;
    localparam logic [63:0] RCP_FULL =
        ((64'd1 << RCP_SH) + 64'(ROW_WORDS) - 64'd1) / 64'(ROW_WORDS);
    localparam logic [RCP_W-1:0] RCP_M = RCP_FULL[RCP_W-1:0];
    localparam int CLR_N     = (MEM_WORDS > REG_COUNT) ? MEM_WORDS : REG_COUNT;
    localparam int CLR_W     = $clog2(CLR_N + 1);

    // memories
    logic [DATA_W-1:0] r_mem [MEM_WORDS];
    logic [DATA_W-1:0] r_rf  [REG_COUNT];
    logic [DATA_W-1:0] r_mem_q;
    logic [DATA_W-1:0] r_rf_qa;
    logic [DATA_W-1:0] r_rf_qb;

    // configuration
    logic [DLY_W-1:0] r_row_delay;
    logic [DLY_W-1:0] r_col_delay;

    // clearing pass
    logic             r_clr_busy;
    logic [CLR_W-1:0] r_clr_cnt;

    // timeline state
    logic                 r_orv;
    logic [ROW_IDX_W-1:0] r_ori;
    logic [DATA_W-1:0]    r_act;
    logic [DATA_W-1:0]    r_cycles;
    logic                 r_pv;
    logic [DATA_W-1:0]    r_pend;
    logic [REG_AW-1:0]    r_pdata;
    logic [REG_AW-1:0]    r_pbase;

    // write-back bypass seen by the item read at the same edge
    logic              r_byp_we;
    logic [REG_AW-1:0] r_byp_addr;
    logic [DATA_W-1:0] r_byp_data;

    // stage 1
    logic              r_s1_valid;
    logic [CMD_W-1:0]  r_s1_cmd;
    logic [REG_AW-1:0] r_s1_rd;
    logic [REG_AW-1:0] r_s1_ra;
    logic [REG_AW-1:0] r_s1_rb;
    logic [REG_AW-1:0] r_s1_bsel;
    logic [DATA_W-1:0] r_s1_imm;

    // stage 2
    logic              r_s2_valid;
    logic [CMD_W-1:0]  r_s2_cmd;
    logic [REG_AW-1:0] r_s2_rd;
    logic [REG_AW-1:0] r_s2_ra;
    logic [REG_AW-1:0] r_s2_rb;
    logic [STAT_W-1:0] r_s2_status;
    logic [DATA_W-1:0] r_s2_value;
    logic [MEM_AW-1:0] r_s2_word;

    // stage 3
    logic                 r_s3_valid;
    logic [CMD_W-1:0]     r_s3_cmd;
    logic [REG_AW-1:0]    r_s3_rd;
    logic [REG_AW-1:0]    r_s3_ra;
    logic [REG_AW-1:0]    r_s3_rb;
    logic [STAT_W-1:0]    r_s3_status;
    logic [DATA_W-1:0]    r_s3_value;
    logic [ROW_IDX_W-1:0] r_s3_row;

    // output register
    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_status;
    logic [DATA_W-1:0] r_out_value;
    logic [OUTC_W-1:0] r_out_outc;
    logic [DATA_W-1:0] r_out_cycles;
    logic [DATA_W-1:0] r_out_act;
    logic [DATA_W-1:0] r_out_pend;

    // handshake
    logic              adv;
    logic              accept;
    logic [CMD_W-1:0]  in_cmd;
    logic [REG_AW-1:0] in_rd;
    logic [REG_AW-1:0] in_ra;
    logic [REG_AW-1:0] in_rb;
    logic [DATA_W-1:0] in_imm;
    logic [REG_AW-1:0] in_bsel;

    assign in_cmd  = s_axis_tuser;
    assign in_rd   = s_axis_tdata[4:0];
    assign in_ra   = s_axis_tdata[9:5];
    assign in_rb   = s_axis_tdata[14:10];
    assign in_imm  = s_axis_tdata[46:15];
    assign in_bsel = (in_cmd == CMD_ADD) ? in_rb : in_rd;

    // pipeline moves as a whole when the output register can take an item
    assign adv = !r_out_valid || m_axis_tready;
    assign s_axis_tready = adv && !r_clr_busy
                        && !(r_s1_valid && r_s1_cmd == CMD_LW)
                        && !(r_s2_valid && r_s2_cmd == CMD_LW);
    assign accept = s_axis_tvalid && s_axis_tready;

    // stage 1 operands with bypass
    logic [DATA_W-1:0] s1_opa;
    logic [DATA_W-1:0] s1_opr;
    logic [DATA_W-1:0] s1_opb;
    logic [DATA_W-1:0] s1_sum;
    logic [DATA_W-1:0] s1_addr;
    logic              s1_ovf;
    logic              s1_is_alu;
    logic              s1_is_mem;
    logic [STAT_W-1:0] s1_status;
    logic [DATA_W-1:0] s1_value;

    always_comb begin
        s1_opa = (r_byp_we && r_byp_addr == r_s1_ra) ? r_byp_data : r_rf_qa;
        s1_opr = (r_byp_we && r_byp_addr == r_s1_bsel) ? r_byp_data : r_rf_qb;
        s1_opb = (r_s1_cmd == CMD_ADD) ? s1_opr : r_s1_imm;
        s1_sum = s1_opa + s1_opb;
        s1_ovf = ((s1_opa[DATA_W-1] ^ s1_sum[DATA_W-1])
               & (s1_opb[DATA_W-1] ^ s1_sum[DATA_W-1]));
        s1_addr = s1_opa + r_s1_imm;
        s1_is_alu = (r_s1_cmd == CMD_ADD) || (r_s1_cmd == CMD_ADDI);
        s1_is_mem = (r_s1_cmd == CMD_LW) || (r_s1_cmd == CMD_SW);
        s1_status = ST_OK;
        s1_value  = '0;
        if ((s1_is_alu || s1_is_mem) && r_s1_rd == '0) begin
            s1_status = ST_ZDEST;
        end else if (s1_is_alu) begin
            s1_status = s1_ovf ? ST_OVF : ST_OK;
            s1_value  = s1_sum;
        end else if (s1_is_mem) begin
            if (s1_addr[1:0] != 2'b00) begin
                s1_status = ST_UNAL;
            end else if (s1_addr[DATA_W-1]
                         || s1_addr[DATA_W-1:2] >= (DATA_W-2)'(MEM_WORDS)) begin
                s1_status = ST_BADDR;
            end else if (r_s1_cmd == CMD_SW) begin
                s1_value = s1_opr;
            end
        end
    end

    // stage 2 row index by reciprocal multiply
    logic [PROD_W-1:0]    s2_prod;
    logic [ROW_IDX_W-1:0] s2_row;

    assign s2_prod = PROD_W'(r_s2_word) * PROD_W'(RCP_M);
    assign s2_row  = ROW_IDX_W'(s2_prod >> RCP_SH);

    // register file write port
    logic              alu_we;
    logic              lw_we;
    logic              clr_rf;
    logic              wb_we;
    logic [REG_AW-1:0] wb_addr;
    logic [DATA_W-1:0] wb_data;
    logic              rf_we;
    logic [REG_AW-1:0] rf_waddr;
    logic [DATA_W-1:0] rf_wdata;

    assign alu_we = adv && r_s1_valid && s1_is_alu && s1_status == ST_OK;
    assign lw_we  = adv && r_s3_valid && r_s3_cmd == CMD_LW && r_s3_status == ST_OK;
    assign clr_rf = r_clr_busy && r_clr_cnt < CLR_W'(REG_COUNT);

    always_comb begin
        wb_we   = alu_we || lw_we;
        wb_addr = alu_we ? r_s1_rd : r_s3_rd;
        wb_data = alu_we ? s1_sum : r_mem_q;
        rf_we    = clr_rf || wb_we;
        rf_waddr = clr_rf ? r_clr_cnt[REG_AW-1:0] : wb_addr;
        rf_wdata = clr_rf ? '0 : wb_data;
    end

    // register file memory, two read ports
    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf[rf_waddr] <= rf_wdata;
        end
        if (accept) begin
            r_rf_qa <= r_rf[in_ra];
            r_rf_qb <= r_rf[in_bsel];
        end
    end

    // word memory write and read port
    logic              clr_mem;
    logic              mem_we;
    logic              mem_re;
    logic [MEM_AW-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;

    assign clr_mem = r_clr_busy && r_clr_cnt < CLR_W'(MEM_WORDS);

    always_comb begin
        mem_we    = clr_mem || (adv && r_s2_valid && r_s2_cmd == CMD_SW
                                && r_s2_status == ST_OK);
        mem_re    = adv && r_s2_valid && r_s2_cmd == CMD_LW && r_s2_status == ST_OK;
        mem_waddr = clr_mem ? r_clr_cnt[MEM_AW-1:0] : r_s2_word;
        mem_wdata = clr_mem ? '0 : r_s2_value;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[r_s2_word];
        end
    end

    // stage 3 timeline update
    logic                 s3_dep;
    logic                 s3_hit;
    logic [DATA_W-1:0]    s3_base;
    logic [DLY_W+2:0]     s3_incr;
    logic [OUTC_W-1:0]    s3_outc;
    logic [DATA_W-1:0]    s3_value;
    logic [DATA_W-1:0]    n_cycles;
    logic [DATA_W-1:0]    n_act;
    logic                 n_pv;
    logic [DATA_W-1:0]    n_pend;
    logic [REG_AW-1:0]    n_pdata;
    logic [REG_AW-1:0]    n_pbase;
    logic                 n_orv;
    logic [ROW_IDX_W-1:0] n_ori;

    always_comb begin
        s3_dep = r_s3_rd == r_pdata || r_s3_rd == r_pbase
              || r_s3_ra == r_pdata || r_s3_ra == r_pbase
              || (r_s3_cmd == CMD_ADD && (r_s3_rb == r_pdata || r_s3_rb == r_pbase));
        s3_hit  = r_orv && r_s3_row == r_ori;
        s3_base = r_pv ? r_pend : r_cycles;
        s3_incr = (DLY_W+3)'(r_col_delay) + (DLY_W+3)'(1);
        n_cycles = r_cycles;
        n_act    = r_act;
        n_pv     = r_pv;
        n_pend   = r_pend;
        n_pdata  = r_pdata;
        n_pbase  = r_pbase;
        n_orv    = r_orv;
        n_ori    = r_ori;
        s3_outc  = OUTC_NONE;
        s3_value = r_s3_value;
        if (r_s3_status == ST_OK) begin
            case (r_s3_cmd) inside
                CMD_ADD, CMD_ADDI: begin
                    if (r_pv && s3_dep) begin
                        n_cycles = r_pend + 32'd1;
                        n_pv     = 1'b0;
                    end else begin
                        n_cycles = r_cycles + 32'd1;
                        if (r_pv && n_cycles == r_pend) begin
                            n_pv = 1'b0;
                        end
                    end
                end
                CMD_LW, CMD_SW: begin
                    if (s3_hit) begin
                        s3_outc = OUTC_HIT;
                    end else if (!r_orv) begin
                        s3_outc = OUTC_CLOSED;
                        n_act   = r_act + 32'd1;
                        s3_incr = s3_incr + (DLY_W+3)'(r_row_delay);
                    end else begin
                        s3_outc = OUTC_CONFLICT;
                        n_act   = r_act + 32'd1;
                        s3_incr = s3_incr + {(DLY_W+3)'(r_row_delay), 1'b0}[DLY_W+2:0];
                    end
                    n_cycles = s3_base + 32'd1;
                    n_pend   = s3_base + DATA_W'(s3_incr);
                    n_pv     = 1'b1;
                    n_pdata  = r_s3_rd;
                    n_pbase  = r_s3_ra;
                    n_orv    = 1'b1;
                    n_ori    = r_s3_row;
                    if (r_s3_cmd == CMD_LW) begin
                        s3_value = r_mem_q;
                    end
                end
                CMD_DRAIN: begin
                    if (r_pv) begin
                        n_cycles = r_pend;
                        n_pv     = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_delay <= ROW_DELAY_RST;
            r_col_delay <= COL_DELAY_RST;
            r_clr_busy  <= 1'b1;
            r_clr_cnt   <= '0;
            r_orv       <= 1'b0;
            r_ori       <= '0;
            r_act       <= '0;
            r_cycles    <= '0;
            r_pv        <= 1'b0;
            r_pend      <= '0;
            r_pdata     <= '0;
            r_pbase     <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ROW_DELAY: r_row_delay <= i_cfg_data;
                    CFG_COL_DELAY: r_col_delay <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            // clearing pass
            if (r_clr_busy) begin
                r_clr_cnt <= r_clr_cnt + CLR_W'(1);
                if (r_clr_cnt == CLR_W'(CLR_N - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            // pipeline valids and timeline
            if (adv) begin
                r_s1_valid  <= accept;
                r_s2_valid  <= r_s1_valid;
                r_s3_valid  <= r_s2_valid;
                r_out_valid <= r_s3_valid;
                if (r_s3_valid) begin
                    r_cycles <= n_cycles;
                    r_act    <= n_act;
                    r_pv     <= n_pv;
                    r_pend   <= n_pend;
                    r_pdata  <= n_pdata;
                    r_pbase  <= n_pbase;
                    r_orv    <= n_orv;
                    r_ori    <= n_ori;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cmd   <= in_cmd;
            r_s1_rd    <= in_rd;
            r_s1_ra    <= in_ra;
            r_s1_rb    <= in_rb;
            r_s1_bsel  <= in_bsel;
            r_s1_imm   <= in_imm;
            r_byp_we   <= wb_we;
            r_byp_addr <= wb_addr;
            r_byp_data <= wb_data;
        end
        if (adv) begin
            r_s2_cmd    <= r_s1_cmd;
            r_s2_rd     <= r_s1_rd;
            r_s2_ra     <= r_s1_ra;
            r_s2_rb     <= r_s1_rb;
            r_s2_status <= s1_status;
            r_s2_value  <= s1_value;
            r_s2_word   <= s1_addr[MEM_AW+1:2];
            r_s3_cmd    <= r_s2_cmd;
            r_s3_rd     <= r_s2_rd;
            r_s3_ra     <= r_s2_ra;
            r_s3_rb     <= r_s2_rb;
            r_s3_status <= r_s2_status;
            r_s3_value  <= r_s2_value;
            r_s3_row    <= s2_row;
            r_out_status <= r_s3_status;
            r_out_value  <= s3_value;
            r_out_outc   <= s3_outc;
            r_out_cycles <= n_cycles;
            r_out_act    <= n_act;
            r_out_pend   <= n_pv ? n_pend : '0;
        end
    end

    // result item
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_pend, r_out_act, r_out_cycles,
                            r_out_outc, r_out_value, r_out_status};

endmodule

### sim/mips_subset_core_with_dram_row_buffer_tb.sv
// ----------------------------------------------------------------------------
// mips_subset_core_with_dram_row_buffer_tb
// Drives decoded add, addi, lw, sw and drain items into the core and compares
// every result item field by field against its typed result or a predictor of
// the register file, word memory and open-row timeline. A short directed table
// comes first, then random phases under several delay settings with random
// idling on both sides in all but one phase, and one long output hold-off.
// ----------------------------------------------------------------------------
module mips_subset_core_with_dram_row_buffer_tb;
    import mipsdram_pkg::*;

    localparam int MEM_WORDS   = DEF_ROW_WORDS * DEF_ROW_COUNT;
    localparam int ROW_BYTES   = DEF_ROW_WORDS * 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 185;
    localparam int HOLD_OFF    = 300;

    // command codes the block ignores
    localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [31:0]       value;
        logic [OUTC_W-1:0] outcome;
        logic [31:0]       cycle_cnt;
        logic [31:0]       act_cnt;
        logic [31:0]       pend_end;
    } retire_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [4:0]       rd;
        logic [4:0]       ra;
        logic [4:0]       rb;
        logic [31:0]      imm;
        logic             typed;
        retire_t          want;
    } instr_row_t;

    // directed items; typed results assume reset delays (row 10, col 2)
    localparam instr_row_t DIR_TABLE [26] = '{
        '{CMD_ADD,   5'd1,  5'd0,  5'd0,  32'h0,        1'b1,
          '{ST_OK,    32'h0,        OUTC_NONE,     32'd1,  32'd0, 32'd0}},
        '{CMD_ADDI,  5'd0,  5'd1,  5'd0,  32'h5,        1'b1,
          '{ST_ZDEST, 32'h0,        OUTC_NONE,     32'd1,  32'd0, 32'd0}},
        '{CMD_ADDI,  5'd2,  5'd0,  5'd0,  32'h7FFFFFFF, 1'b1,
          '{ST_OK,    32'h7FFFFFFF, OUTC_NONE,     32'd2,  32'd0, 32'd0}},
        '{CMD_ADDI,  5'd3,  5'd2,  5'd0,  32'h1,        1'b1,
          '{ST_OVF,   32'h80000000, OUTC_NONE,     32'd2,  32'd0, 32'd0}},
        '{CMD_ADDI,  5'd4,  5'd0,  5'd0,  32'h80000000, 1'b1,
          '{ST_OK,    32'h80000000, OUTC_NONE,     32'd3,  32'd0, 32'd0}},
        '{CMD_ADDI,  5'd5,  5'd4,  5'd0,  32'hFFFFFFFF, 1'b1,
          '{ST_OVF,   32'h7FFFFFFF, OUTC_NONE,     32'd3,  32'd0, 32'd0}},
        '{CMD_ADD,   5'd6,  5'd2,  5'd2,  32'h0,        1'b1,
          '{ST_OVF,   32'hFFFFFFFE, OUTC_NONE,     32'd3,  32'd0, 32'd0}},
        '{CMD_ADD,   5'd7,  5'd4,  5'd4,  32'h0,        1'b1,
          '{ST_OVF,   32'h0,        OUTC_NONE,     32'd3,  32'd0, 32'd0}},
        '{CMD_SW,    5'd2,  5'd0,  5'd0,  32'h1,        1'b1,
          '{ST_UNAL,  32'h0,        OUTC_NONE,     32'd3,  32'd0, 32'd0}},
        '{CMD_LW,    5'd2,  5'd0,  5'd0,  32'h2,        1'b1,
          '{ST_UNAL,  32'h0,        OUTC_NONE,     32'd3,  32'd0, 32'd0}},
        '{CMD_LW,    5'd8,  5'd4,  5'd0,  32'h0,        1'b1,
          '{ST_BADDR, 32'h0,        OUTC_NONE,     32'd3,  32'd0, 32'd0}},
        '{CMD_SW,    5'd2,  5'd0,  5'd0,  32'h00010000, 1'b1,
          '{ST_BADDR, 32'h0,        OUTC_NONE,     32'd3,  32'd0, 32'd0}},
        '{CMD_SW,    5'd0,  5'd0,  5'd0,  32'h00010000, 1'b1,
          '{ST_ZDEST, 32'h0,        OUTC_NONE,     32'd3,  32'd0, 32'd0}},
        '{CMD_SW,    5'd2,  5'd0,  5'd0,  32'h0000FFFC, 1'b1,
          '{ST_OK,    32'h7FFFFFFF, OUTC_CLOSED,   32'd4,  32'd1, 32'd16}},
        '{CMD_LW,    5'd9,  5'd0,  5'd0,  32'h0000FFFC, 1'b1,
          '{ST_OK,    32'h7FFFFFFF, OUTC_HIT,      32'd17, 32'd1, 32'd19}},
        '{CMD_ADD,   5'd10, 5'd9,  5'd0,  32'h0,        1'b1,
          '{ST_OK,    32'h7FFFFFFF, OUTC_NONE,     32'd20, 32'd1, 32'd0}},
        '{CMD_LW,    5'd11, 5'd0,  5'd0,  32'h0,        1'b1,
          '{ST_OK,    32'h0,        OUTC_CONFLICT, 32'd21, 32'd2, 32'd43}},
        '{CMD_ADDI,  5'd12, 5'd2,  5'd0,  32'hFFFFFFFF, 1'b1,
          '{ST_OK,    32'h7FFFFFFE, OUTC_NONE,     32'd22, 32'd2, 32'd43}},
        '{CMD_DRAIN, 5'd0,  5'd0,  5'd0,  32'h0,        1'b1,
          '{ST_OK,    32'h0,        OUTC_NONE,     32'd43, 32'd2, 32'd0}},
        '{CMD_DRAIN, 5'd0,  5'd0,  5'd0,  32'h0,        1'b1,
          '{ST_OK,    32'h0,        OUTC_NONE,     32'd43, 32'd2, 32'd0}},
        '{CMD_RSVD_HI, 5'd0, 5'd0, 5'd0,  32'h0,        1'b1,
          '{ST_OK,    32'h0,        OUTC_NONE,     32'd43, 32'd2, 32'd0}},
        '{CMD_RSVD_LO, 5'd31, 5'd31, 5'd31, 32'hFFFFFFFF, 1'b1,
          '{ST_OK,    32'h0,        OUTC_NONE,     32'd43, 32'd2, 32'd0}},
        '{CMD_SW,    5'd10, 5'd0,  5'd0,  32'h4,        1'b1,
          '{ST_OK,    32'h7FFFFFFF, OUTC_HIT,      32'd44, 32'd2, 32'd46}},
        '{CMD_ADDI,  5'd13, 5'd0,  5'd0,  32'h3,        1'b1,
          '{ST_OK,    32'h3,        OUTC_NONE,     32'd47, 32'd2, 32'd0}},
        '{CMD_LW,    5'd14, 5'd13, 5'd0,  32'h1,        1'b0, '0},
        '{CMD_ADD,   5'd15, 5'd14, 5'd13, 32'h0,        1'b0, '0}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [CMD_W-1:0]     s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 i_cfg_we;
    logic [CFG_AW-1:0]    i_cfg_index;
    logic [DLY_W-1:0]     i_cfg_data;

    mips_subset_core_with_dram_row_buffer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // predictor state
    bit [31:0]   gpr [REG_COUNT];
    bit [31:0]   dmem [MEM_WORDS];
    bit          row_open;
    int unsigned open_row;
    bit [31:0]   activ_cnt;
    bit [31:0]   sim_cycles;
    bit          req_busy;
    bit [31:0]   req_end;
    bit [4:0]    req_data;
    bit [4:0]    req_base;
    bit [15:0]   row_dly = ROW_DELAY_RST;
    bit [15:0]   col_dly = COL_DELAY_RST;

    retire_t     retire_q [$];
    int          mismatches;
    int          cycle_no;

    // item currently offered, with its typed result if any
    logic        offer_typed;
    retire_t     offer_want;

    // idling controls
    bit          tx_idle_on;
    bit          rx_idle_on;
    bit          hold_off_req;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic bit hits_pending(logic [4:0] r);
        return r == req_data || r == req_base;
    endfunction

    // one instruction through the predictor: updates state, returns its result
    function automatic retire_t core_execute(logic [CMD_W-1:0] cmd, logic [4:0] rd,
                                             logic [4:0] ra, logic [4:0] rb,
                                             logic [31:0] imm);
        retire_t     res;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] sum;
        logic [31:0] addr;
        logic [31:0] lat;
        int unsigned word;
        int unsigned row;
        bit          dep;
        res = '0;
        res.status  = ST_OK;
        res.outcome = OUTC_NONE;
        if (cmd <= CMD_SW && rd == 5'd0) begin
            res.status = ST_ZDEST;
        end else if (cmd == CMD_ADD || cmd == CMD_ADDI) begin
            a = gpr[ra];
            b = (cmd == CMD_ADD) ? gpr[rb] : imm;
            sum = a + b;
            res.value = sum;
            if (((a ^ sum) & (b ^ sum)) >> 31) begin
                res.status = ST_OVF;
            end else begin
                gpr[rd] = sum;
                dep = hits_pending(rd) || hits_pending(ra) ||
                      (cmd == CMD_ADD && hits_pending(rb));
                if (req_busy && dep) begin
                    sim_cycles = req_end + 1;
                    req_busy = 1'b0;
                end else begin
                    sim_cycles = sim_cycles + 1;
                    if (req_busy && sim_cycles == req_end)
                        req_busy = 1'b0;
                end
            end
        end else if (cmd == CMD_LW || cmd == CMD_SW) begin
            addr = gpr[ra] + imm;
            if (addr[1:0] != 2'b00) begin
                res.status = ST_UNAL;
            end else if (addr[31] || addr[31:2] >= MEM_WORDS) begin
                res.status = ST_BADDR;
            end else begin
                word = addr[31:2];
                row  = word / DEF_ROW_WORDS;
                if (req_busy) begin
                    sim_cycles = req_end;
                    req_busy = 1'b0;
                end
                sim_cycles = sim_cycles + 1;
                if (row_open && row == open_row) begin
                    res.outcome = OUTC_HIT;
                    lat = {16'd0, col_dly};
                end else if (!row_open) begin
                    res.outcome = OUTC_CLOSED;
                    activ_cnt = activ_cnt + 1;
                    lat = {16'd0, row_dly} + {16'd0, col_dly};
                end else begin
                    res.outcome = OUTC_CONFLICT;
                    activ_cnt = activ_cnt + 1;
                    lat = 2 * {16'd0, row_dly} + {16'd0, col_dly};
                end
                row_open = 1'b1;
                open_row = row & 32'h3FF;
                if (cmd == CMD_LW) begin
                    res.value = dmem[word];
                    gpr[rd] = dmem[word];
                end else begin
                    res.value = gpr[rd];
                    dmem[word] = gpr[rd];
                end
                req_busy = 1'b1;
                req_end  = sim_cycles + lat;
                req_data = rd;
                req_base = ra;
            end
        end else if (cmd == CMD_DRAIN) begin
            if (req_busy) begin
                sim_cycles = req_end;
                req_busy = 1'b0;
            end
        end
        res.cycle_cnt = sim_cycles;
        res.act_cnt   = activ_cnt;
        res.pend_end  = req_busy ? req_end : 32'd0;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatches < 40)
            $display("mismatch at cycle %0d: %s got %h want %h", cycle_no, what, got, want);
        mismatches++;
    endtask

    // accept items into the predictor and check result items in order
    always @(posedge i_clk) begin : check_proc
        retire_t pred;
        retire_t got;
        retire_t want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                pred = core_execute(s_axis_tuser, s_axis_tdata[4:0], s_axis_tdata[9:5],
                                    s_axis_tdata[14:10], s_axis_tdata[46:15]);
                retire_q.push_back(offer_typed ? offer_want : pred);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.status    = m_axis_tdata[2:0];
                got.value     = m_axis_tdata[34:3];
                got.outcome   = m_axis_tdata[36:35];
                got.cycle_cnt = m_axis_tdata[68:37];
                got.act_cnt   = m_axis_tdata[100:69];
                got.pend_end  = m_axis_tdata[132:101];
                if (retire_q.size() == 0) begin
                    report_mismatch("unexpected result, status", got.status, 0);
                end else begin
                    want = retire_q.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.value !== want.value)
                        report_mismatch("value", got.value, want.value);
                    if (got.outcome !== want.outcome)
                        report_mismatch("row_outcome", got.outcome, want.outcome);
                    if (got.cycle_cnt !== want.cycle_cnt)
                        report_mismatch("cycle_count", got.cycle_cnt, want.cycle_cnt);
                    if (got.act_cnt !== want.act_cnt)
                        report_mismatch("activation_count", got.act_cnt, want.act_cnt);
                    if (got.pend_end !== want.pend_end)
                        report_mismatch("pending_end", got.pend_end, want.pend_end);
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no > CYCLE_LIMIT) begin
            $display("mips_subset_core_with_dram_row_buffer_tb: errors");
            $finish;
        end
    end

    // result side: random stalls and one long hold-off
    initial begin : rx_proc
        int hold_left;
        hold_left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left = HOLD_OFF;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !(rx_idle_on && $urandom_range(0, 99) < 7);
            end
        end
    end

    // offer one item and hold it until accepted; called at a falling edge
    task automatic send_item(logic [CMD_W-1:0] cmd, logic [4:0] rd, logic [4:0] ra,
                             logic [4:0] rb, logic [31:0] imm, logic typed,
                             retire_t want);
        while (tx_idle_on && $urandom_range(0, 99) < 7) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        offer_typed = typed;
        offer_want  = want;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, imm, rb, ra, rd};
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_AW-1:0] idx, logic [DLY_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == CFG_ROW_DELAY)
            row_dly = val;
        else
            col_dly = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // wait until every expected result is back and the pipeline is empty
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (retire_q.size() != 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    // aligned byte address, mostly in a few hot rows
    function automatic logic [31:0] pick_address();
        int unsigned row;
        row = ($urandom_range(0, 3) == 0) ? $urandom_range(0, DEF_ROW_COUNT - 1)
                                          : $urandom_range(0, 2);
        return row * ROW_BYTES + $urandom_range(0, DEF_ROW_WORDS - 1) * 4;
    endfunction

    // random instruction mix; most memory items aim at valid addresses through
    // the current register contents
    task automatic play_random(int n);
        int unsigned pick;
        logic [CMD_W-1:0] cmd;
        logic [4:0]  rd;
        logic [4:0]  ra;
        logic [4:0]  rb;
        logic [31:0] imm;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            rd   = $urandom_range(0, 31);
            ra   = $urandom_range(0, 31);
            rb   = $urandom_range(0, 31);
            imm  = $urandom;
            if (pick < 15) begin
                cmd = CMD_ADD;
                if ($urandom_range(0, 4) == 0)
                    rb = req_data;
            end else if (pick < 35) begin
                cmd = CMD_ADDI;
                case ($urandom_range(0, 3))
                    0, 1: begin
                        ra  = 5'd0;
                        imm = pick_address();
                    end
                    2: imm = $urandom_range(0, 32) - 16;
                    default: ;
                endcase
                if ($urandom_range(0, 4) == 0)
                    ra = req_data;
            end else if (pick < 80) begin
                cmd = (pick < 60) ? CMD_LW : CMD_SW;
                imm = pick_address() - gpr[ra];
            end else if (pick < 86) begin
                cmd = $urandom_range(0, 1) ? CMD_LW : CMD_SW;
                if ($urandom_range(0, 1))
                    imm = pick_address() - gpr[ra] + $urandom_range(1, 3);
            end else if (pick < 92) begin
                cmd = CMD_DRAIN;
            end else if (pick < 95) begin
                cmd = $urandom_range(CMD_RSVD_LO, CMD_RSVD_HI);
            end else begin
                cmd = $urandom_range(0, 7);
            end
            send_item(cmd, rd, ra, rb, imm, 1'b0, '0);
        end
    endtask

    // main sequence
    initial begin : main_proc
        logic [DLY_W-1:0] row_set [5];
        logic [DLY_W-1:0] col_set [5];
        row_set = '{16'd1, 16'd65535, 16'd1, 16'd65535, 16'($urandom_range(1, 65535))};
        col_set = '{16'd1, 16'd65535, 16'd65535, 16'd1, 16'($urandom_range(1, 65535))};
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        offer_typed   = 1'b0;
        offer_want    = '0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        hold_off_req  = 1'b0;
        mismatches    = 0;
        cycle_no      = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table at reset delays
        foreach (DIR_TABLE[k])
            send_item(DIR_TABLE[k].cmd, DIR_TABLE[k].rd, DIR_TABLE[k].ra, DIR_TABLE[k].rb,
                      DIR_TABLE[k].imm, DIR_TABLE[k].typed, DIR_TABLE[k].want);

        // random phases under different delay settings
        for (int p = 0; p < 5; p++) begin
            wait_quiet();
            cfg_write(CFG_ROW_DELAY, row_set[p]);
            cfg_write(CFG_COL_DELAY, col_set[p]);
            tx_idle_on = (p != 2);
            rx_idle_on = (p != 2);
            if (p == 0)
                hold_off_req = 1'b1;
            play_random(PHASE_ITEMS);
        end

        wait_quiet();
        if (mismatches == 0)
            $display("mips_subset_core_with_dram_row_buffer_tb: clean");
        else
            $display("mips_subset_core_with_dram_row_buffer_tb: errors");
        $finish;
    end

endmodule
